FILE: hw/rtl/mac_learning_table_with_aging_assert.svh
// Assertion macros for the forwarding table
`ifndef MAC_LEARNING_TABLE_WITH_AGING_ASSERT_SVH
`define MAC_LEARNING_TABLE_WITH_AGING_ASSERT_SVH

// same-cycle implication
`define MLT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MLT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/mlt_pkg.sv
`default_nettype none

package mlt_pkg;

    localparam int TABLE_ENTRIES = 256;  // power of two
    localparam int NUM_PORTS     = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int PORT_W        = 4;
    localparam int MAC_W         = 48;
    localparam int STAMP_W       = 16;
    localparam int AGE_W         = 10;
    localparam int COUNT_W       = 9;
    localparam int ACT_W         = 2;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = AGE_W'(30);

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LEARN  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [PORT_W-1:0]  port;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        entry_t             wdata;
        logic [IDX_W-1:0]   raddr;
    } mem_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] aged_count;
        logic [PORT_W-1:0]  found_port;
        logic               hit;
    } res_t;

    function automatic logic [IDX_W-1:0] slot_of(input logic [MAC_W-1:0] mac);
        return mac[MAC_W-8 +: IDX_W];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mlt_ram.sv
`default_nettype none

module mlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mlt_engine.sv
`default_nettype none
`include "mac_learning_table_with_aging_assert.svh"

module mlt_engine
    import mlt_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [ACT_W-1:0]   in_action,
    input  wire logic [MAC_W-1:0]   in_mac,
    input  wire logic [PORT_W-1:0]  in_port,
    input  wire logic [AGE_W-1:0]   age_limit,
    output mem_req_t                mem_req,
    input  wire logic [ENTRY_W-1:0] mem_rdata,
    input  wire logic               out_free,
    output logic                    res_valid,
    output res_t                    res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_SWEEP_END,
        ST_RESP
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    state_t                     state_reg, state_next;
    logic [ACT_W-1:0]           act_reg, act_next;
    logic [MAC_W-1:0]           mac_reg, mac_next;
    logic [PORT_W-1:0]          port_reg, port_next;
    logic [IDX_W-1:0]           slot_reg, slot_next;
    logic [STAMP_W-1:0]         seconds_reg, seconds_next;
    logic [TABLE_ENTRIES-1:0]   valid_reg, valid_next;
    logic [IDX_W-1:0]           sweep_idx_reg, sweep_idx_next;
    logic                       chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]           chk_idx_reg, chk_idx_next;
    logic [COUNT_W-1:0]         aged_cnt_reg, aged_cnt_next;

    entry_t             rd;
    logic [STAMP_W-1:0] age;
    logic               lookup_hit;
    logic               port_ok;

    assign rd         = entry_t'(mem_rdata);
    assign age        = seconds_reg - rd.stamp;
    assign lookup_hit = valid_reg[slot_reg] && (rd.mac == mac_reg);
    assign port_ok    = (32'(port_reg) < NUM_PORTS);
    assign in_ready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        mac_next       = mac_reg;
        port_next      = port_reg;
        slot_next      = slot_reg;
        seconds_next   = seconds_reg;
        valid_next     = valid_reg;
        sweep_idx_next = sweep_idx_reg;
        aged_cnt_next  = aged_cnt_reg;
        chk_vld_next   = (state_reg == ST_SWEEP);
        chk_idx_next   = sweep_idx_reg;

        mem_req.we     = 1'b0;
        mem_req.waddr  = slot_reg;
        mem_req.wdata  = '{mac: mac_reg, port: port_reg, stamp: seconds_reg};
        mem_req.raddr  = slot_reg;

        res_valid      = 1'b0;
        res            = '0;

        // aging check, one entry behind the sweep read
        if (chk_vld_reg && valid_reg[chk_idx_reg] &&
            (age > {{(STAMP_W-AGE_W){1'b0}}, age_limit})) begin
            valid_next[chk_idx_reg] = 1'b0;
            aged_cnt_next           = aged_cnt_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                mem_req.raddr = slot_of(in_mac);
                if (in_valid) begin
                    act_next  = in_action;
                    mac_next  = in_mac;
                    port_next = in_port;
                    slot_next = slot_of(in_mac);
                    if (in_action == ACT_TICK) begin
                        seconds_next   = seconds_reg + 1'b1;
                        sweep_idx_next = '0;
                        aged_cnt_next  = '0;
                        state_next     = ST_SWEEP;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    case (act_reg)
                        ACT_LOOKUP: begin
                            if (lookup_hit) begin
                                res.hit          = 1'b1;
                                res.found_port   = rd.port;
                                mem_req.we       = 1'b1;
                                mem_req.wdata.port = rd.port;
                            end
                        end
                        ACT_LEARN: begin
                            if (port_ok) begin
                                mem_req.we          = 1'b1;
                                valid_next[slot_reg] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                mem_req.raddr  = sweep_idx_reg;
                sweep_idx_next = sweep_idx_reg + 1'b1;
                if (sweep_idx_reg == LAST_IDX) begin
                    state_next = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    res_valid      = 1'b1;
                    res.aged_count = aged_cnt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seconds_reg   <= '0;
            valid_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            aged_cnt_reg  <= '0;
            sweep_idx_reg <= '0;
        end else begin
            state_reg     <= state_next;
            seconds_reg   <= seconds_next;
            valid_reg     <= valid_next;
            chk_vld_reg   <= chk_vld_next;
            aged_cnt_reg  <= aged_cnt_next;
            sweep_idx_reg <= sweep_idx_next;
        end
        act_reg     <= act_next;
        mac_reg     <= mac_next;
        port_reg    <= port_next;
        slot_reg    <= slot_next;
        chk_idx_reg <= chk_idx_next;
    end

    `MLT_ASSERT_IMP(a_res_has_room, aclk, aresetn, res_valid, out_free)
    `MLT_ASSERT_NXT(a_tick_advances, aclk, aresetn,
        in_valid && in_ready && (in_action == ACT_TICK),
        seconds_reg == $past(seconds_reg) + 1'b1)
    `MLT_ASSERT_NXT(a_sweep_ends, aclk, aresetn,
        (state_reg == ST_SWEEP) && (sweep_idx_reg == LAST_IDX),
        state_reg == ST_SWEEP_END)
    `MLT_ASSERT_IMP(a_hit_only_lookup, aclk, aresetn,
        res_valid && res.hit, (state_reg == ST_EXEC) && (act_reg == ACT_LOOKUP))
    `MLT_ASSERT_IMP(a_count_bound, aclk, aresetn,
        1'b1, 32'(aged_cnt_reg) <= TABLE_ENTRIES)

endmodule

`default_nettype wire

FILE: hw/rtl/mac_learning_table_with_aging.sv
// Lookup, learn and unused actions: one table read, then a write on a lookup hit or a learn.
// Tick: the aging sweep reads one table entry per cycle.
// The result goes from ST_EXEC (tick: ST_RESP, after the sweep) to the output register once it has room.
// A new transaction is taken while the previous result waits in the output register.
// Reset: all entries invalid, seconds counter 0, age_limit 30; no clearing pass.
`default_nettype none

module mac_learning_table_with_aging
    import mlt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // mac_address[47:0], port_number[51:48], zero pad
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // hit[0], found_port[4:1], aged_count[13:5], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [AGE_W-1:0] cfg_data  // age_limit
);

    logic [AGE_W-1:0] age_limit_reg;
    logic             m_valid_reg, m_valid_next;
    res_t             m_res_reg, m_res_next;

    mem_req_t         mem_req;
    logic [ENTRY_W-1:0] mem_rdata;
    logic             out_free;
    logic             res_valid;
    res_t             res;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    mlt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    mlt_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_mac    (s_tdata[MAC_W-1:0]),
        .in_port   (s_tdata[MAC_W +: PORT_W]),
        .age_limit (age_limit_reg),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_limit_reg <= AGE_LIMIT_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                age_limit_reg <= cfg_data;
            end
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16 - $bits(res_t)){1'b0}}, m_res_reg};

endmodule

`default_nettype wire

FILE: sim/mac_learning_table_with_aging_tb.sv
`default_nettype none

module mac_learning_table_with_aging_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlt_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int POOL_SIZE       = 24;
    localparam int FRAMES_PER_PHASE = 24;
    localparam int WATCHDOG_LIMIT  = 8 * (TABLE_ENTRIES + 3);
    localparam int NUM_PHASES      = 7;
    localparam logic [AGE_W-1:0] PHASE_AGE [NUM_PHASES] = '{
        AGE_W'(1023), AGE_W'(0), AGE_W'(1), AGE_W'(3), AGE_W'(2), AGE_W'(30), AGE_W'(5)
    };

    class fwd_table_tracker;
        bit                 live      [TABLE_ENTRIES];
        logic [MAC_W-1:0]   owner_mac [TABLE_ENTRIES];
        logic [PORT_W-1:0]  owner_port[TABLE_ENTRIES];
        logic [STAMP_W-1:0] last_seen [TABLE_ENTRIES];
        logic [STAMP_W-1:0] clock_sec;
        logic [AGE_W-1:0]   max_age;
        res_t               pending_replies[$];
        int unsigned        errors;

        function new();
            foreach (live[i]) begin
                live[i]       = 1'b0;
                owner_mac[i]  = '0;
                owner_port[i] = '0;
                last_seen[i]  = '0;
            end
            clock_sec = '0;
            max_age   = AGE_LIMIT_RESET;
            errors    = 0;
        endfunction

        function void note_frame(input logic [ACT_W-1:0] act, input logic [MAC_W-1:0] mac,
                                 input logic [PORT_W-1:0] port);
            int unsigned        idx;
            logic [STAMP_W-1:0] age;
            res_t               r;
            idx = mac[MAC_W-1 -: 8] % TABLE_ENTRIES;
            r = '0;
            case (act)
                ACT_LOOKUP: begin
                    if (live[idx] && owner_mac[idx] == mac) begin
                        r.hit        = 1'b1;
                        r.found_port = owner_port[idx];
                        last_seen[idx] = clock_sec;
                    end
                end
                ACT_LEARN: begin
                    if (port < NUM_PORTS) begin
                        live[idx]       = 1'b1;
                        owner_mac[idx]  = mac;
                        owner_port[idx] = port;
                        last_seen[idx]  = clock_sec;
                    end
                end
                ACT_TICK: begin
                    clock_sec = clock_sec + 1'b1;
                    foreach (live[i]) begin
                        age = clock_sec - last_seen[i];
                        if (live[i] && age > max_age) begin
                            live[i] = 1'b0;
                            r.aged_count = r.aged_count + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            pending_replies.push_back(r);
        endfunction

        function void check_reply(input logic [15:0] data);
            res_t got, want;
            got = res_t'(data[$bits(res_t)-1:0]);
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.hit !== want.hit) begin
                $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                errors++;
            end
            if (got.found_port !== want.found_port) begin
                $display("%0t: found_port expected %0d actual %0d",
                         $time, want.found_port, got.found_port);
                errors++;
            end
            if (got.aged_count !== want.aged_count) begin
                $display("%0t: aged_count expected %0d actual %0d",
                         $time, want.aged_count, got.aged_count);
                errors++;
            end
        endfunction
    endclass

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [55:0]      s_tdata   = '0;   // mac_address[47:0], port_number[51:48], zero pad
    logic [1:0]       s_tuser   = '0;   // action[1:0]
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [15:0]      m_tdata;          // hit[0], found_port[4:1], aged_count[13:5], zero pad
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [AGE_W-1:0] cfg_data  = '0;

    fwd_table_tracker fwd_model = new();
    logic [MAC_W-1:0] mac_pool [POOL_SIZE];
    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      random_frames  = 0;
    int unsigned      quiet_cycles   = 0;

    mac_learning_table_with_aging DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            fwd_model.check_reply(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] fresh_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // drop valid and hold off until every reply is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (fwd_model.pending_replies.size() != 0);
    endtask

    task automatic write_age_limit(input logic [AGE_W-1:0] lim);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        fwd_model.max_age = lim;
    endtask

    task automatic send_frame(input logic [ACT_W-1:0] act, input logic [MAC_W-1:0] mac,
                              input logic [PORT_W-1:0] port);
        if ($urandom_range(0, 49) == 0)
            wait_drained();
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, port, mac};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        fwd_model.note_frame(act, mac, port);
    endtask

    task automatic send_random_frame();
        int unsigned      roll;
        logic [MAC_W-1:0] mac;
        roll = $urandom_range(0, 99);
        mac  = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 45) begin
            if ($urandom_range(0, 9) == 0)
                mac = fresh_mac();
            else if ($urandom_range(0, 9) == 0)
                mac[31:0] = mac[31:0] ^ $urandom;   // same slot, other address
            send_frame(ACT_LOOKUP, mac, 4'($urandom));
            random_frames++;
        end else if (roll < 82) begin
            if ($urandom_range(0, 15) == 0) begin
                mac = fresh_mac();
                mac_pool[$urandom_range(0, POOL_SIZE - 1)] = mac;
            end
            send_frame(ACT_LEARN, mac, 4'($urandom));
            random_frames++;
        end else if (roll < 94) begin
            send_frame(ACT_TICK, fresh_mac(), 4'($urandom));
            random_frames++;
        end else begin
            send_frame(ACT_UNUSED, fresh_mac(), 4'($urandom));
        end
    endtask

    initial begin
        logic [MAC_W-1:0] addr;

        for (int i = 0; i < POOL_SIZE; i++) begin
            mac_pool[i] = fresh_mac();
            if (i % 4 == 3)
                mac_pool[i][47:40] = mac_pool[i-1][47:40];
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extreme addresses, slot collisions, unused action, ticks
        send_frame(ACT_LOOKUP, 48'h0000_0000_0000, 4'd0);
        send_frame(ACT_LEARN,  48'hFFFF_FFFF_FFFF, 4'd15);
        send_frame(ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'd0);
        send_frame(ACT_LEARN,  48'h0000_0000_0000, 4'd0);
        send_frame(ACT_LOOKUP, 48'h0000_0000_0000, 4'd15);
        send_frame(ACT_LOOKUP, 48'h0000_0000_0001, 4'd0);
        send_frame(ACT_LOOKUP, 48'hFFFF_FFFF_FFFE, 4'd0);
        send_frame(ACT_UNUSED, 48'hFFFF_FFFF_FFFF, 4'd15);
        send_frame(ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'd0);
        send_frame(ACT_LEARN,  48'h0123_4567_89AB, 4'd9);
        send_frame(ACT_LEARN,  48'h01FF_FFFF_FFFF, 4'd6);
        send_frame(ACT_LOOKUP, 48'h0123_4567_89AB, 4'd0);
        send_frame(ACT_LOOKUP, 48'h01FF_FFFF_FFFF, 4'd0);
        send_frame(ACT_TICK,   48'h0000_0000_0000, 4'd0);
        send_frame(ACT_TICK,   48'hA5A5_A5A5_A5A5, 4'd10);
        send_frame(ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'd5);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_age_limit(PHASE_AGE[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (PHASE_AGE[p] == 0) begin
                // fill every slot, then one tick clears the whole table
                for (int s = 0; s < TABLE_ENTRIES; s++) begin
                    addr = fresh_mac();
                    addr[47:40] = 8'(s);
                    send_frame(ACT_LEARN, addr, 4'($urandom));
                end
                send_frame(ACT_TICK, fresh_mac(), 4'($urandom));
            end
            random_frames = 0;
            while (random_frames < FRAMES_PER_PHASE)
                send_random_frame();
        end

        wait_drained();
        recv_stall_pct = 0;
        repeat (TABLE_ENTRIES + 8) @(posedge aclk);

        if (fwd_model.pending_replies.size() != 0) begin
            $display("%0t: %0d transactions expected, 0 actual",
                     $time, fwd_model.pending_replies.size());
            fwd_model.errors++;
        end
        if (fwd_model.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mlt_pkg.sv
hw/rtl/mlt_ram.sv
hw/rtl/mlt_engine.sv
hw/rtl/mac_learning_table_with_aging.sv
sim/mac_learning_table_with_aging_tb.sv
